/* rtl/core/tosq_pkg.sv */
// ----------------------------------------------------------------------------
// tosq_pkg
// shared constants, command codes and the op beat type of the schedule queue
// ----------------------------------------------------------------------------
package tosq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned FREE_W      = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_PUSH,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               level;
    logic [DELAY_W-1:0] delay;
  } op_t;

endpackage

/* rtl/core/tosq_front.sv */
// ----------------------------------------------------------------------------
// tosq_front
// accepts input beats and classifies the command into an op for the back end
// ----------------------------------------------------------------------------
module tosq_front import tosq_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic               event_level_i,
  input  logic [DELAY_W-1:0] event_delay_i,
  output logic               op_valid_o,
  input  logic               op_ready_i,
  output op_t                op_o
);

  // query and the unused code both turn into a no-op
  always_comb begin
    op_o.level = event_level_i;
    op_o.delay = event_delay_i;
    case (command_i)
      CMD_PUSH:  op_o.op = OP_PUSH;
      CMD_TICK:  op_o.op = OP_TICK;
      CMD_QUERY: op_o.op = OP_NOP;
      default:   op_o.op = OP_NOP;
    endcase
  end

  assign op_valid_o = in_valid_i;
  assign in_ready_o = op_ready_i;

endmodule

/* rtl/core/tosq_op_fifo.sv */
// ----------------------------------------------------------------------------
// tosq_op_fifo
// two-entry op queue that decouples the front end from the back end
// ----------------------------------------------------------------------------
module tosq_op_fifo import tosq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  op_t  wr_op_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output op_t  rd_op_o
);

  op_t        buf_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_op_o    = buf_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/core/tosq_back.sv */
// ----------------------------------------------------------------------------
// tosq_back
// executes ops against the event slots and registers one result per op
// ----------------------------------------------------------------------------
module tosq_back import tosq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  op_t               op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [FREE_W-1:0] free_slots_o,
  output logic              pin_level_o,
  output logic              pin_written_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(QUEUE_DEPTH - 1);

  logic [DELAY_W-1:0] slot_delay_q [QUEUE_DEPTH];
  logic               slot_level_q [QUEUE_DEPTH];

  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               driven_q, driven_d;

  logic               out_valid_q;
  logic               status_q, status_d;
  logic [FREE_W-1:0]  free_q;
  logic               written_q, written_d;

  logic               take;
  logic               empty;
  logic               full;
  logic [DELAY_W-1:0] head_delay;
  logic               head_level;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [DELAY_W-1:0] wr_delay;
  logic               wr_level;
  logic [CNT_W-1:0]   free_d;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign take       = op_valid_i && op_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == DEPTH_C);
  assign head_delay = slot_delay_q[head_q];
  assign head_level = slot_level_q[head_q];

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    driven_d  = driven_q;
    status_d  = 1'b0;
    written_d = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = tail_q;
    wr_delay  = op_i.delay;
    wr_level  = op_i.level;
    case (op_i.op)
      OP_PUSH: begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          tail_d  = (tail_q == LAST_C) ? '0 : tail_q + IDX_W'(1);
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_TICK: begin
        if (!empty) begin
          if (head_delay != '0) begin
            // count the head event down in place
            wr_en    = 1'b1;
            wr_idx   = head_q;
            wr_delay = head_delay - DELAY_W'(1);
            wr_level = head_level;
          end else begin
            driven_d  = head_level;
            head_d    = (head_q == LAST_C) ? '0 : head_q + IDX_W'(1);
            count_d   = count_q - CNT_W'(1);
            written_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign free_d = DEPTH_C - count_d;

  always_ff @(posedge clk_i) begin
    if (take && wr_en) begin
      slot_delay_q[wr_idx] <= wr_delay;
      slot_level_q[wr_idx] <= wr_level;
    end
    if (take) begin
      status_q  <= status_d;
      free_q    <= FREE_W'(free_d);
      written_q <= written_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      driven_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        driven_q    <= driven_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign free_slots_o  = free_q;
  assign pin_level_o   = driven_q;
  assign pin_written_o = written_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_C)
    else $error("entry count above queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && op_i.op == OP_PUSH && full |=> status_q && $stable(count_q))
    else $error("push on full queue not refused");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && op_i.op == OP_PUSH && !full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted push did not grow the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && written_q |-> !status_q)
    else $error("fired tick flagged as refused push");

endmodule

/* rtl/core/timed_output_schedule_queue_unit.sv */
// ----------------------------------------------------------------------------
// timed_output_schedule_queue_unit
// bounded queue of delayed pin events driven by push, query and tick beats
// an accepted beat is registered in the op queue, then its result in the back-end result register
// throughput: one beat per cycle while the result channel does not stall, set by the back-end op step
// a two-entry op queue lets input and output stall independently
// reset (rst_ni low, async): queue empty, pin low, no result pending
// slot contents are not cleared; only entries written by a push are read
// ----------------------------------------------------------------------------
module timed_output_schedule_queue_unit import tosq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beat channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic               event_level_i,
  input  logic [DELAY_W-1:0] event_delay_i,
  // result beat channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic [FREE_W-1:0]  free_slots_o,
  output logic               pin_level_o,
  output logic               pin_written_o
);

  // front end to op queue
  logic fr_valid;
  logic fr_ready;
  op_t  fr_op;

  // op queue to back end
  logic bk_valid;
  logic bk_ready;
  op_t  bk_op;

  // decode the command into push, tick or no-op
  tosq_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .event_level_i(event_level_i),
    .event_delay_i(event_delay_i),
    .op_valid_o   (fr_valid),
    .op_ready_i   (fr_ready),
    .op_o         (fr_op)
  );

  // short queue so a stalled result does not block input beats at once
  tosq_op_fifo u_op_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_op_i   (fr_op),
    .rd_valid_o(bk_valid),
    .rd_ready_i(bk_ready),
    .rd_op_o   (bk_op)
  );

  // slot storage, head/tail pointers, pin level and the result register
  tosq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (bk_valid),
    .op_ready_o   (bk_ready),
    .op_i         (bk_op),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .free_slots_o (free_slots_o),
    .pin_level_o  (pin_level_o),
    .pin_written_o(pin_written_o)
  );

endmodule
